// ===== hw/rtl/salc_pkg.sv =====
package salc_pkg;

    // Width of the configuration write port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 6;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_SET_BITS = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_OFF_BITS = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_WAYS     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [2:0] SET_BITS_RST = 3'd4;
    localparam logic [5:0] OFF_BITS_RST = 6'd4;
    localparam logic [3:0] WAYS_RST     = 4'd1;

    // One stored line: valid, tag, last-use stamp
    localparam int TAG_W   = 64;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 32;
    localparam int LINE_W  = 1 + TAG_W + STAMP_W;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_STORE  = 2'd1,
        CMD_MODIFY = 2'd2,
        CMD_FETCH  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_REREAD
    } t_state;

endpackage

// ===== hw/rtl/salc_ram.sv =====
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/set_assoc_lru_cache_tags_top.sv =====
// Set-associative tag directory with LRU replacement. Each input transaction is one
// memory reference; a load or store gives one result, a modify gives two (the second
// marked last_of_run), an instruction fetch gives none. A whole set (all ways: valid,
// tag, stamp) sits in one row of a single synchronous RAM. An access first reads the set
// row, then compares all configured ways in parallel, picks the line and writes the row
// back; the write-back waits while the result register cannot take the outcome. A modify
// makes two such accesses, rereading the row for the second; a fetch is only accepted.
// After reset the block sweeps every row of the RAM to clear it and accepts no
// transaction until done; configuration writes are taken at any time.
module set_assoc_lru_cache_tags_top #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [salc_pkg::CFG_AW-1:0]  i_cfg_index,
    input  logic [salc_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_command,
    input  logic [63:0]                  i_address,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_was_hit,
    output logic                         o_was_miss,
    output logic                         o_was_eviction,
    output logic                         o_last_of_run,
    output logic [31:0]                  o_hit_total,
    output logic [31:0]                  o_miss_total,
    output logic [31:0]                  o_eviction_total
);

    import salc_pkg::*;

    localparam int DEPTH  = 2 ** MAX_SET_BITS;
    localparam int SET_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_AW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ROW_W  = MAX_WAYS * LINE_W;

    // Configuration
    logic [2:0]  r_set_bits;
    logic [5:0]  r_off_bits;
    logic [3:0]  r_ways;

    // Control and working registers
    t_state              r_state, n_state;
    logic [SET_AW-1:0]   r_clr_addr, n_clr_addr;
    logic [SET_AW-1:0]   r_set, n_set;
    logic [TAG_W-1:0]    r_tag, n_tag;
    logic                r_modify, n_modify;
    logic                r_second, n_second;
    logic [STAMP_W-1:0]  r_clock, n_clock;
    logic [CNT_W-1:0]    r_hits, n_hits;
    logic [CNT_W-1:0]    r_misses, n_misses;
    logic [CNT_W-1:0]    r_evicts, n_evicts;

    // Result register
    logic r_out_valid, n_out_valid;
    logic r_out_hit, n_out_hit;
    logic r_out_evict, n_out_evict;
    logic r_out_last, n_out_last;

    // Memory port
    logic              w_we, w_re;
    logic [SET_AW-1:0] w_waddr, w_raddr;
    logic [ROW_W-1:0]  w_wdata, w_rdata;

    // Address split of the incoming transaction
    logic [2:0]        w_sbits;
    logic [6:0]        w_shift;
    logic [SET_AW-1:0] w_set_mask;
    logic [63:0]       w_off_shifted;
    logic [SET_AW-1:0] w_in_set;
    logic [TAG_W-1:0]  w_in_tag;

    // Lookup
    logic [4:0]          w_ways;
    logic [MAX_WAYS-1:0] w_active;
    logic                w_hit;
    logic                w_free;
    logic [WAY_AW-1:0]   w_hit_way, w_free_way, w_lru_way, w_pick;
    logic [STAMP_W-1:0]  w_oldest;
    logic [STAMP_W-1:0]  w_stamp_new;
    logic [ROW_W-1:0]    w_row_new;
    logic                w_out_free;
    logic                w_accept;

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits <= SET_BITS_RST;
            r_off_bits <= OFF_BITS_RST;
            r_ways     <= WAYS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SET_BITS: r_set_bits <= i_cfg_data[2:0];
                CFG_OFF_BITS: r_off_bits <= i_cfg_data[5:0];
                CFG_WAYS:     r_ways     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Split the incoming address into set and tag
    always_comb begin
        if (int'(r_set_bits) > MAX_SET_BITS) begin
            w_sbits = 3'(MAX_SET_BITS);
        end else begin
            w_sbits = r_set_bits;
        end
        w_shift = 7'(w_sbits) + 7'(r_off_bits);
        for (int k = 0; k < SET_AW; k++) begin
            w_set_mask[k] = (k < int'(w_sbits));
        end
        w_off_shifted = i_address >> r_off_bits;
        w_in_set      = w_off_shifted[SET_AW-1:0] & w_set_mask;
        if (w_shift[6]) begin
            w_in_tag = '0;
        end else begin
            w_in_tag = i_address >> w_shift[5:0];
        end
    end

    // Compare the configured ways of the set row that was read
    always_comb begin
        logic                 v;
        logic [TAG_W-1:0]     tg;
        logic [STAMP_W-1:0]   st;
        if (r_ways == 4'd0) begin
            w_ways = 5'd1;
        end else if (int'(r_ways) > MAX_WAYS) begin
            w_ways = 5'(MAX_WAYS);
        end else begin
            w_ways = 5'(r_ways);
        end
        w_hit      = 1'b0;
        w_free     = 1'b0;
        w_hit_way  = '0;
        w_free_way = '0;
        w_lru_way  = '0;
        w_oldest   = '0;
        // Scan downward so the lowest matching or free way wins
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            w_active[w] = (5'(w) < w_ways);
            v  = w_rdata[w*LINE_W + LINE_W - 1];
            tg = w_rdata[w*LINE_W + STAMP_W +: TAG_W];
            if (w_active[w] && v && tg == r_tag) begin
                w_hit     = 1'b1;
                w_hit_way = WAY_AW'(w);
            end
            if (w_active[w] && !v) begin
                w_free     = 1'b1;
                w_free_way = WAY_AW'(w);
            end
        end
        // Oldest stamp; ties go to the highest way
        for (int w = 0; w < MAX_WAYS; w++) begin
            st = w_rdata[w*LINE_W +: STAMP_W];
            if (w == 0) begin
                w_oldest  = st;
                w_lru_way = '0;
            end else if (w_active[w] && st <= w_oldest) begin
                w_oldest  = st;
                w_lru_way = WAY_AW'(w);
            end
        end
        if (w_hit) begin
            w_pick = w_hit_way;
        end else if (w_free) begin
            w_pick = w_free_way;
        end else begin
            w_pick = w_lru_way;
        end
        w_stamp_new = r_clock + 1'b1;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_AW'(w) == w_pick) begin
                w_row_new[w*LINE_W +: LINE_W] = {1'b1, r_tag, w_stamp_new};
            end else begin
                w_row_new[w*LINE_W +: LINE_W] = w_rdata[w*LINE_W +: LINE_W];
            end
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_set       = r_set;
        n_tag       = r_tag;
        n_modify    = r_modify;
        n_second    = r_second;
        n_clock     = r_clock;
        n_hits      = r_hits;
        n_misses    = r_misses;
        n_evicts    = r_evicts;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_hit   = r_out_hit;
        n_out_evict = r_out_evict;
        n_out_last  = r_out_last;
        o_in_ready  = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_set;
        w_wdata     = w_row_new;
        w_re        = 1'b0;
        w_raddr     = r_set;

        case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == SET_AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                w_raddr    = w_in_set;
                if (w_accept && i_command != CMD_FETCH) begin
                    w_re     = 1'b1;
                    n_set    = w_in_set;
                    n_tag    = w_in_tag;
                    n_modify = (i_command == CMD_MODIFY);
                    n_second = 1'b0;
                    n_state  = S_LOOK;
                end
            end
            S_LOOK: begin
                // Hold here until the result register can take the outcome
                if (w_out_free) begin
                    w_we        = 1'b1;
                    n_clock     = w_stamp_new;
                    n_out_valid = 1'b1;
                    n_out_hit   = w_hit;
                    n_out_evict = !w_hit && !w_free;
                    n_out_last  = !r_modify || r_second;
                    if (w_hit) begin
                        n_hits = r_hits + 1'b1;
                    end else begin
                        n_misses = r_misses + 1'b1;
                        if (!w_free) begin
                            n_evicts = r_evicts + 1'b1;
                        end
                    end
                    if (r_modify && !r_second) begin
                        n_second = 1'b1;
                        n_state  = S_REREAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_REREAD: begin
                // Row was written last cycle; read it again for the second access
                w_re    = 1'b1;
                n_state = S_LOOK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_modify    <= 1'b0;
            r_second    <= 1'b0;
            r_clock     <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_modify    <= n_modify;
            r_second    <= n_second;
            r_clock     <= n_clock;
            r_hits      <= n_hits;
            r_misses    <= n_misses;
            r_evicts    <= n_evicts;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_set       <= n_set;
        r_tag       <= n_tag;
        r_out_hit   <= n_out_hit;
        r_out_evict <= n_out_evict;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid      = r_out_valid;
    assign o_was_hit        = r_out_hit;
    assign o_was_miss       = !r_out_hit;
    assign o_was_eviction   = r_out_evict;
    assign o_last_of_run    = r_out_last;
    assign o_hit_total      = r_hits;
    assign o_miss_total     = r_misses;
    assign o_eviction_total = r_evicts;

    // No result may appear while the RAM is still being cleared
    a_no_out_in_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result valid during clearing pass");

    // An eviction only comes with a miss
    a_evict_is_miss : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_evict) |-> !r_out_hit)
        else $error("eviction reported on a hit");

    // Each completed access bumps exactly one of the hit and miss totals
    a_one_total : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && w_out_free) |=>
            ((r_hits - $past(r_hits)) + (r_misses - $past(r_misses)) == 32'd1))
        else $error("hit and miss totals out of step");

    // A modify always passes through the reread of the same row
    a_reread_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REREAD) |=> (r_state == S_LOOK && r_second && r_modify))
        else $error("second access of modify lost");

endmodule
